/* rtl/core/vlc_pkg.sv */
`default_nettype none

package vlc_pkg;

  // input command codes
  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  // width mode codes
  localparam logic WIDTH_32 = 1'b0;
  localparam logic WIDTH_64 = 1'b1;
  localparam logic WIDTH_MODE_RESET = WIDTH_64;

  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned GROUP_W  = 7;
  localparam int unsigned COUNT_W  = 4;

  localparam logic [GROUP_W-1:0] GROUP_MASK = 7'h7F;
  localparam logic [BYTE_W-1:0]  CONT_FLAG  = 8'h80;

  // group limits per width, and the highest count ever kept
  localparam logic [COUNT_W-1:0] LIMIT_32  = 4'd5;
  localparam logic [COUNT_W-1:0] LIMIT_64  = 4'd10;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd9;

  // one result beat
  typedef struct packed {
    logic [BYTE_W-1:0]  byte_out;
    logic [VALUE_W-1:0] value_out;
    logic               value_valid;
    logic               overflow_error;
    logic               last;
  } beat_t;

endpackage

`default_nettype wire

/* rtl/core/vlc_decoder.sv */
`default_nettype none

module vlc_decoder (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       step,
  input  wire logic [7:0]                 byte_in,
  input  wire logic                       wide,
  output vlc_pkg::beat_t                  beat,
  output logic                            has_result
);
  import vlc_pkg::*;

  logic [VALUE_W-1:0] acc;
  logic [COUNT_W-1:0] gc;

  logic [COUNT_W-1:0] gc_c;
  logic [COUNT_W-1:0] gc_inc;
  logic [COUNT_W-1:0] limit;
  logic [6:0]         sh_full;
  logic [5:0]         sh;
  logic [VALUE_W-1:0] acc_new;
  logic               done;
  logic               ovf;

  always_comb begin
    gc_c    = (gc > COUNT_MAX) ? COUNT_MAX : gc;
    // times seven without a multiplier
    sh_full = {gc_c, 3'b000} - {3'b000, gc_c};
    sh      = sh_full[5:0];
    acc_new = acc | ({{(VALUE_W-GROUP_W){1'b0}}, byte_in[GROUP_W-1:0] & GROUP_MASK} << sh);
    done    = (byte_in & CONT_FLAG) == '0;
    gc_inc  = gc_c + 4'd1;
    limit   = wide ? LIMIT_64 : LIMIT_32;
    ovf     = !done && (gc_inc >= limit);
    has_result = done || ovf;

    beat.byte_out       = '0;
    beat.value_out      = '0;
    if (done) begin
      beat.value_out = wide ? acc_new : {32'b0, acc_new[31:0]};
    end
    beat.value_valid    = done;
    beat.overflow_error = ovf;
    beat.last           = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      gc  <= '0;
    end else if (step) begin
      if (has_result) begin
        acc <= '0;
        gc  <= '0;
      end else begin
        acc <= acc_new;
        gc  <= gc_inc;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/varint_codec.sv */
`default_nettype none

// unsigned leb128 varint codec, 32-bit or 64-bit values
//
// input stream s_axis: tuser selects the command (encode or decode), tdata
// carries the value to encode and the byte to decode. output stream m_axis:
// one beat per encoded byte, or one beat for a finished decode or an
// overflow; tlast marks the final beat caused by an input beat.
// cfg channel: one-bit width mode (0 = 32-bit, 1 = 64-bit), always ready,
// to be written only while the codec is idle.
//
// an input beat lands in the work register at the accepting edge, and its
// first result is registered from there into the output stage, which drives
// m_axis_tvalid; a stalled output stage holds the work register back.
// a decode beat takes a single step; an encode beat produces 1 to 5 bytes in
// 32-bit mode and 1 to 10 in 64-bit mode, one per step of the single
// byte-emitting work register, which takes its next item as it finishes one.
// when m_axis stalls, the output stage holds its beat and the work register
// holds its item; s_axis_tready drops once both are occupied, and also while
// an encode still has bytes left to send.
// reset clears the decode state, empties both stages and selects 64-bit mode.

module varint_codec (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data,       // width_mode
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,   // [63:0] value_in, [71:64] byte_in
  input  wire logic        s_axis_tuser,   // [0] cmd
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // [7:0] byte_out, [71:8] value_out
  output logic [1:0]       m_axis_tuser,   // [0] value_valid, [1] overflow_error
  output logic             m_axis_tlast    // last
);
  import vlc_pkg::*;

  logic width_mode;

  // work register
  logic               work_valid;
  logic               work_cmd;
  logic [VALUE_W-1:0] work_val;
  logic [BYTE_W-1:0]  work_byte;

  // output stage
  logic  out_valid;
  beat_t out_beat;

  logic  adv;
  logic  fire_work;
  logic  rest_nz;
  logic  work_done;
  logic  emit;
  logic  s_accept;
  beat_t enc_beat;
  beat_t dec_beat;
  logic  dec_has_result;
  logic  dec_step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_mode <= WIDTH_MODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      width_mode <= cfg_data;
    end
  end

  // output stage free or emptying this cycle
  assign adv       = !out_valid || m_axis_tready;
  assign fire_work = work_valid && adv;
  assign rest_nz   = |work_val[VALUE_W-1:GROUP_W];
  assign work_done = fire_work && ((work_cmd == CMD_DECODE) || !rest_nz);
  assign dec_step  = fire_work && (work_cmd == CMD_DECODE);
  assign emit      = fire_work && ((work_cmd == CMD_ENCODE) || dec_has_result);

  assign s_axis_tready = !work_valid || work_done;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // encode: one 7-bit group per beat, continuation flag while bits remain
  always_comb begin
    enc_beat.byte_out       = {rest_nz, work_val[GROUP_W-1:0] & GROUP_MASK};
    enc_beat.value_out      = '0;
    enc_beat.value_valid    = 1'b0;
    enc_beat.overflow_error = 1'b0;
    enc_beat.last           = !rest_nz;
  end

  vlc_decoder u_decoder (
    .clk        (clk),
    .rst        (rst),
    .step       (dec_step),
    .byte_in    (work_byte),
    .wide       (width_mode),
    .beat       (dec_beat),
    .has_result (dec_has_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else if (s_accept) begin
      work_valid <= 1'b1;
    end else if (work_done) begin
      work_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      work_cmd  <= s_axis_tuser;
      work_val  <= (width_mode == WIDTH_64) ? s_axis_tdata[63:0]
                                            : {32'b0, s_axis_tdata[31:0]};
      work_byte <= s_axis_tdata[71:64];
    end else if (fire_work && (work_cmd == CMD_ENCODE)) begin
      // drop the group just sent
      work_val <= work_val >> GROUP_W;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_beat <= (work_cmd == CMD_ENCODE) ? enc_beat : dec_beat;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_beat.value_out, out_beat.byte_out};
  assign m_axis_tuser  = {out_beat.overflow_error, out_beat.value_valid};
  assign m_axis_tlast  = out_beat.last;

  // a decode beat is either a value or an error, never both
  a_dec_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("decode beat flags both value and overflow");

  // encoded bytes carry the continuation flag exactly when not last
  a_enc_cont: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0] && !m_axis_tuser[1])
      |-> (m_axis_tdata[7] == !m_axis_tlast))
    else $error("continuation flag disagrees with tlast");

  // an encode with bytes still to send keeps the input closed
  a_enc_hold: assert property (@(posedge clk) disable iff (rst)
    (work_valid && (work_cmd == CMD_ENCODE) && rest_nz) |-> !s_axis_tready)
    else $error("input accepted during a multi-byte encode");

endmodule

`default_nettype wire
